FILE: hw/rtl/fvws_pkg.sv
// ----------------------------------------------------------------------------
// fvws_pkg
// Shared widths, constants and types of the four-voice wavetable synth.
// ----------------------------------------------------------------------------
package fvws_pkg;

  // voice count and register file geometry
  localparam int NUM_VOICES = 4;
  localparam int VOICE_W    = 2;
  localparam int ADDR_W     = 4;
  localparam int DATA_W     = 32;

  // 10.16 step format, raw register width
  localparam int STEP_W = 26;
  localparam int FRAC_W = 16;

  // sample widths
  localparam int VOL_W    = 12;
  localparam int SAMPLE_W = 12;
  localparam int ROM_W    = 16;

  // mix and scale widths: four Q15 terms, then times a 12-bit volume
  localparam int MIX_W   = ROM_W + 2;
  localparam int PROD_W  = MIX_W + VOL_W + 1;
  localparam int SCALE_W = PROD_W - FRAC_W;

  // output mapping
  localparam logic [VOL_W-1:0]    VOL_RESET = 12'd2048;
  localparam logic [SCALE_W:0]    DAC_MID   = 16'sd2048;
  localparam logic [SCALE_W:0]    DAC_MAX   = 16'sd4095;
  localparam logic [SAMPLE_W-1:0] DAC_TOP   = 12'd4095;
  localparam logic [SAMPLE_W-1:0] DAC_ZERO  = 12'd0;
  localparam int                  SINE_PEAK = 32767;

  // step reduction result handed from the modulo unit to the step registers
  typedef struct packed {
    logic               valid;
    logic [VOICE_W-1:0] voice;
  } step_upd_t;

endpackage

FILE: hw/rtl/fvws_ram.sv
// ----------------------------------------------------------------------------
// fvws_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module fvws_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read ports, data held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule

FILE: hw/rtl/fvws_sine_rom.sv
// ----------------------------------------------------------------------------
// fvws_sine_rom
// Sine table with registered reads, held in two dual-read RAMs, filled after
// reset from a table computed at elaboration in Q4.60 fixed point.
// ----------------------------------------------------------------------------
module fvws_sine_rom
  import fvws_pkg::*;
#(
  parameter int TABLE_SIZE = 1000
) (
  input  logic                                             clk,
  input  logic                                             rst,
  input  logic                                             rd_en,
  input  logic [NUM_VOICES-1:0][$clog2(TABLE_SIZE)-1:0]    rd_idx,
  output logic [NUM_VOICES-1:0][ROM_W-1:0]                 rd_data,
  output logic                                             busy
);

  localparam int IW = $clog2(TABLE_SIZE);

  localparam logic [63:0] PI_Q60  = 64'h3243F6A8885A308D;
  localparam logic [63:0] N64     = 64'(TABLE_SIZE);
  localparam logic [63:0] TWO_N   = 64'(2 * TABLE_SIZE);
  localparam logic [63:0] LO32    = 64'hFFFF_FFFF;
  localparam logic [63:0] LO30    = 64'h3FFF_FFFF;
  localparam logic [63:0] PEAK64  = 64'(SINE_PEAK);

  // (2k)(2k+1) for the Taylor terms, k = 1..23
  localparam logic [63:0] TAYLOR_DEN [24] = '{
    64'd1,    64'd6,    64'd20,   64'd42,   64'd72,   64'd110,  64'd156,  64'd210,
    64'd272,  64'd342,  64'd420,  64'd506,  64'd600,  64'd702,  64'd812,  64'd930,
    64'd1056, 64'd1190, 64'd1332, 64'd1482, 64'd1640, 64'd1806, 64'd1980, 64'd2162
  };

  // (a * b) >> 60 with truncating partial products
  function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] ah, al, bh, bl;
    ah = a >> 32;
    al = a & LO32;
    bh = b >> 32;
    bl = b & LO32;
    return ((ah * bh) << 4) + ((ah * bl + al * bh) >> 28) + ((al * bl) >> 60);
  endfunction

  // trunc(32767 * sin(2*pi*i/TABLE_SIZE)) as Q15
  function automatic logic [ROM_W-1:0] sine_entry(input int unsigned i);
    logic [63:0]        m, x, x2, term, s, mag, ph, qh, pl;
    logic signed [63:0] sum;
    logic               neg;
    int unsigned        k;
    neg = 1'b0;
    mag = '0;
    m   = 64'(i) << 2;
    if (m >= TWO_N) begin
      neg = 1'b1;
      m   = m - TWO_N;
    end
    if (m > N64) begin
      m = TWO_N - m;
    end
    if (m == N64) begin
      mag = PEAK64;
    end else if (m != 64'd0) begin
      // angle = pi * m / (2n) in Q4.60
      ph = (PI_Q60 >> 32) * m;
      qh = ph / TWO_N;
      pl = ((ph % TWO_N) << 32) + (PI_Q60 & LO32) * m;
      x  = (qh << 32) + pl / TWO_N;
      x2   = mul_q60(x, x);
      term = x;
      sum  = $signed(x);
      for (k = 1; (k < 24) && (term != 64'd0); k++) begin
        term = mul_q60(term, x2) / TAYLOR_DEN[k];
        if (k[0]) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
      s   = (sum > 0) ? $unsigned(sum) : 64'd0;
      mag = (PEAK64 * (s >> 30) + ((PEAK64 * (s & LO30)) >> 30)) >> 30;
      if (mag > PEAK64) begin
        mag = PEAK64;
      end
    end
    return neg ? ROM_W'(64'd0 - mag) : ROM_W'(mag);
  endfunction

  function automatic logic [TABLE_SIZE-1:0][ROM_W-1:0] build_tab();
    logic [TABLE_SIZE-1:0][ROM_W-1:0] tab;
    for (int unsigned i = 0; i < TABLE_SIZE; i++) begin
      tab[i] = sine_entry(i);
    end
    return tab;
  endfunction

  localparam logic [TABLE_SIZE-1:0][ROM_W-1:0] SINE_TAB = build_tab();

  logic          filling;
  logic [IW-1:0] fill_addr;
  logic [ROM_W-1:0] fill_data;

  // fill sweep, one entry per cycle after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      filling   <= 1'b1;
      fill_addr <= '0;
    end else if (filling) begin
      if (fill_addr == IW'(TABLE_SIZE - 1)) begin
        filling <= 1'b0;
      end
      fill_addr <= fill_addr + 1'b1;
    end
  end

  assign fill_data = SINE_TAB[fill_addr];
  assign busy      = filling;

  // voices A/B read copy 0, voices C/D read copy 1
  fvws_ram #(
    .WIDTH (ROM_W),
    .DEPTH (TABLE_SIZE)
  ) u_ram0 (
    .clk    (clk),
    .we     (filling),
    .waddr  (fill_addr),
    .wdata  (fill_data),
    .re     (rd_en),
    .raddr0 (rd_idx[0]),
    .raddr1 (rd_idx[1]),
    .rdata0 (rd_data[0]),
    .rdata1 (rd_data[1])
  );

  fvws_ram #(
    .WIDTH (ROM_W),
    .DEPTH (TABLE_SIZE)
  ) u_ram1 (
    .clk    (clk),
    .we     (filling),
    .waddr  (fill_addr),
    .wdata  (fill_data),
    .re     (rd_en),
    .raddr0 (rd_idx[2]),
    .raddr1 (rd_idx[3]),
    .rdata0 (rd_data[2]),
    .rdata1 (rd_data[3])
  );

endmodule

FILE: hw/rtl/fvws_step_mod.sv
// ----------------------------------------------------------------------------
// fvws_step_mod
// Reduces a written step modulo TABLE_SIZE<<16: reciprocal multiply for the
// quotient, then one multiply-subtract and one correction.
// ----------------------------------------------------------------------------
module fvws_step_mod
  import fvws_pkg::*;
#(
  parameter int TABLE_SIZE = 1000
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 wr,
  input  logic [VOICE_W-1:0]                   wr_voice,
  input  logic [STEP_W-1:0]                    wr_step,
  output step_upd_t                            upd,
  output logic [$clog2(TABLE_SIZE)+FRAC_W-1:0] red_step,
  output logic                                 busy
);

  localparam int IW       = $clog2(TABLE_SIZE);
  localparam int XW       = STEP_W - FRAC_W;
  localparam int RECIP_SH = 20;
  localparam int MW       = RECIP_SH + 1;
  localparam int QPW      = XW + MW;
  localparam int TPW      = XW + IW + 1;
  localparam int RW       = ((IW > XW) ? IW : XW) + 1;
  localparam logic [MW-1:0] RECIP = MW'((1 << RECIP_SH) / TABLE_SIZE);

  logic               a_valid, b_valid;
  logic [VOICE_W-1:0] a_voice, b_voice;
  logic [XW-1:0]      a_x, b_x, b_q;
  logic [FRAC_W-1:0]  a_frac, b_frac;
  logic [QPW-1:0]     qprod;
  logic [TPW-1:0]     tprod;
  logic [XW-1:0]      rem;
  logic [RW-1:0]      rem_w, rem_fix;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      a_valid <= wr;
      b_valid <= a_valid;
    end
  end

  // estimated quotient, at most one low
  assign qprod = QPW'(a_x) * QPW'(RECIP);

  always_ff @(posedge clk) begin
    if (wr) begin
      a_voice <= wr_voice;
      a_x     <= wr_step[STEP_W-1:FRAC_W];
      a_frac  <= wr_step[FRAC_W-1:0];
    end
    b_voice <= a_voice;
    b_x     <= a_x;
    b_frac  <= a_frac;
    b_q     <= qprod[RECIP_SH +: XW];
  end

  // remainder below twice the table size, one subtract to fix
  assign tprod   = TPW'(b_q) * TPW'(TABLE_SIZE);
  assign rem     = b_x - tprod[XW-1:0];
  assign rem_w   = RW'(rem);
  assign rem_fix = (rem_w >= RW'(TABLE_SIZE)) ? (rem_w - RW'(TABLE_SIZE)) : rem_w;

  assign upd.valid = b_valid;
  assign upd.voice = b_voice;
  assign red_step  = {rem_fix[IW-1:0], b_frac};
  assign busy      = a_valid | b_valid;

endmodule

FILE: hw/rtl/four_voice_wavetable_synth_unit.sv
// ----------------------------------------------------------------------------
// four_voice_wavetable_synth_unit
// Four-voice sine wavetable synthesizer producing one 12-bit DAC code per
// sample tick.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall/volume_sample): one transaction per
//   sample tick; the volume given is applied on the following tick.
//   Output channel (out_valid/out_stall/dac_sample): one transaction per
//   input transaction, in order.
//   Pipeline: dac_sample is registered behind the phase update and table
//   read, mix, multiply, and combined offset-and-clamp stages.
//   Throughput: one transaction per cycle; the next input is taken while a
//   finished result waits in the output register, until every stage is full.
//   Reset: phases and steps clear, held volume goes to 2048, and the sine
//   table is loaded from its constant image while in_stall is held high.
//   APB writes are taken meanwhile.
//   APB: steps of voices A..D at byte addresses 0, 4, 8, 12. A write holds
//   off input while the step is reduced modulo the table span.
//   Writing a zero step clears that voice's phase.
//   When out_stall is high the result holds and the stages behind it fill up.
// ----------------------------------------------------------------------------
module four_voice_wavetable_synth_unit
  import fvws_pkg::*;
#(
  parameter int TABLE_SIZE = 1000
) (
  input  logic                clk,
  input  logic                rst,
  // APB
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready,
  // input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [VOL_W-1:0]    volume_sample,
  // output channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic [SAMPLE_W-1:0] dac_sample
);

  localparam int IW = $clog2(TABLE_SIZE);
  localparam int PW = IW + FRAC_W;
  localparam logic [PW:0] SPAN = (PW + 1)'(TABLE_SIZE) << FRAC_W;

  logic [STEP_W-1:0] step_raw [NUM_VOICES];
  logic [PW-1:0]     step_red [NUM_VOICES];
  logic [PW-1:0]     phase    [NUM_VOICES];
  logic [PW-1:0]     phase_next [NUM_VOICES];
  logic [VOL_W-1:0]  held_volume;

  logic [NUM_VOICES-1:0][IW-1:0]    rd_idx;
  logic [NUM_VOICES-1:0][ROM_W-1:0] rd_data;

  logic                cfg_wr;
  logic [VOICE_W-1:0]  cfg_voice;
  logic [STEP_W-1:0]   cfg_step;
  step_upd_t           upd;
  logic [PW-1:0]       red_step;
  logic                mod_busy, rom_busy;

  logic                accept;
  logic                s1_valid, s2_valid, s3_valid;
  logic                s1_ready, s2_ready, s3_ready, out_ready;
  logic [VOL_W-1:0]    s1_vol, s2_vol;
  logic signed [MIX_W-1:0]  s2_mix, mix_c;
  logic signed [PROD_W-1:0] s3_prod, prod_c, mix_ext, vol_ext;
  logic signed [SCALE_W-1:0] scaled;
  logic signed [SCALE_W:0]   biased;
  logic [SAMPLE_W-1:0]       dac_c;

  // ---------------- configuration port ----------------
  assign pready    = 1'b1;
  assign cfg_wr    = psel & penable & pwrite & pready;
  assign cfg_voice = paddr[ADDR_W-1:2];
  assign cfg_step  = pwdata[STEP_W-1:0];
  assign prdata    = DATA_W'(step_raw[cfg_voice]);

  fvws_step_mod #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_step_mod (
    .clk      (clk),
    .rst      (rst),
    .wr       (cfg_wr),
    .wr_voice (cfg_voice),
    .wr_step  (cfg_step),
    .upd      (upd),
    .red_step (red_step),
    .busy     (mod_busy)
  );

  // ---------------- handshake and stage readiness ----------------
  assign out_ready = ~out_valid | ~out_stall;
  assign s3_ready  = ~s3_valid | out_ready;
  assign s2_ready  = ~s2_valid | s3_ready;
  assign s1_ready  = ~s1_valid | s2_ready;
  assign in_stall  = rom_busy | mod_busy | ~s1_ready;
  assign accept    = in_valid & ~in_stall;

  // ---------------- phase accumulators ----------------
  for (genvar v = 0; v < NUM_VOICES; v++) begin : g_voice
    logic [PW:0] psum;
    logic [PW:0] pwrap;
    assign psum          = (PW + 1)'(phase[v]) + (PW + 1)'(step_red[v]);
    assign pwrap         = (psum >= SPAN) ? (psum - SPAN) : psum;
    assign phase_next[v] = pwrap[PW-1:0];
    assign rd_idx[v]     = phase_next[v][PW-1:FRAC_W];
  end

  // steps, phases and held volume
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int v = 0; v < NUM_VOICES; v++) begin
        step_raw[v] <= '0;
        step_red[v] <= '0;
        phase[v]    <= '0;
      end
      held_volume <= VOL_RESET;
    end else begin
      if (accept) begin
        for (int v = 0; v < NUM_VOICES; v++) begin
          phase[v] <= phase_next[v];
        end
        held_volume <= volume_sample;
      end
      if (upd.valid) begin
        step_red[upd.voice] <= red_step;
      end
      if (cfg_wr) begin
        step_raw[cfg_voice] <= cfg_step;
        if (cfg_step == '0) begin
          phase[cfg_voice] <= '0;
        end
      end
    end
  end

  // ---------------- sine table ----------------
  fvws_sine_rom #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_sine_rom (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_idx  (rd_idx),
    .rd_data (rd_data),
    .busy    (rom_busy)
  );

  // ---------------- datapath ----------------
  // mix of four Q15 lookups
  assign mix_c = MIX_W'($signed(rd_data[0])) + MIX_W'($signed(rd_data[1]))
               + MIX_W'($signed(rd_data[2])) + MIX_W'($signed(rd_data[3]));

  // volume scaling
  assign mix_ext = PROD_W'(s2_mix);
  assign vol_ext = $signed(PROD_W'(s2_vol));
  assign prod_c  = mix_ext * vol_ext;

  // floor shift by 16, offset to mid-scale, clamp to DAC range
  assign scaled = s3_prod[PROD_W-1:FRAC_W];
  assign biased = (SCALE_W + 1)'(scaled) + $signed(DAC_MID);

  always_comb begin
    priority if (biased < 0) begin
      dac_c = DAC_ZERO;
    end else if (biased > $signed(DAC_MAX)) begin
      dac_c = DAC_TOP;
    end else begin
      dac_c = biased[SAMPLE_W-1:0];
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= accept;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
      if (s3_ready) begin
        s3_valid <= s2_valid;
      end
      if (out_ready) begin
        out_valid <= s3_valid;
      end
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_vol <= held_volume;
    end
    if (s2_ready) begin
      s2_mix <= mix_c;
      s2_vol <= s1_vol;
    end
    if (s3_ready) begin
      s3_prod <= prod_c;
    end
    if (out_ready) begin
      dac_sample <= dac_c;
    end
  end

  // ---------------- assertions ----------------
  a_phase_in_span: assert property (@(posedge clk) disable iff (rst)
    ((PW + 1)'(phase[0]) < SPAN) && ((PW + 1)'(phase[1]) < SPAN) &&
    ((PW + 1)'(phase[2]) < SPAN) && ((PW + 1)'(phase[3]) < SPAN))
    else $error("phase accumulator beyond table span");

  a_step_in_span: assert property (@(posedge clk) disable iff (rst)
    upd.valid |-> ((PW + 1)'(red_step) < SPAN))
    else $error("reduced step beyond table span");

  a_zero_step_clears: assert property (@(posedge clk) disable iff (rst)
    (cfg_wr && (cfg_step == '0)) |=> (phase[$past(cfg_voice)] == '0))
    else $error("zero step did not clear phase");

  a_volume_delay: assert property (@(posedge clk) disable iff (rst)
    accept |=> (s1_valid && (s1_vol == $past(held_volume)) &&
                (held_volume == $past(volume_sample))))
    else $error("volume not carried to the next tick");

  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (rst)
    (upd.valid || rom_busy) |-> !accept)
    else $error("item accepted while steps or table not settled");

endmodule

FILE: verif/four_voice_wavetable_synth_unit_test.sv
// ----------------------------------------------------------------------------
// four_voice_wavetable_synth_unit_test
// Self-checking bench for the four-voice wavetable synth. It programs the
// voice steps over APB while the unit is idle, streams volume samples at it,
// and compares every DAC code against a bit-exact software model of the
// accumulators, the sine table, the volume scaling and the clamp. Sender gaps
// and receiver stalls are varied by phase, with one long output hold-off.
// ----------------------------------------------------------------------------
module four_voice_wavetable_synth_unit_test
  import fvws_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int                TBL          = 1000;
  localparam logic [31:0]       SPAN         = 32'(TBL) << FRAC_W;
  localparam logic [63:0]       PI_Q60       = 64'h3243F6A8885A308D;
  localparam logic [STEP_W-1:0] QUARTER_STEP = STEP_W'(250) << FRAC_W;
  localparam logic [STEP_W-1:0] STEP_ALL1    = {STEP_W{1'b1}};
  localparam int                LONG_HOLD    = 300;
  localparam int                DRAIN_CYCLES = 8;
  localparam int                CYCLE_LIMIT  = 200000;
  localparam int                RAND_PHASES  = 8;
  localparam int                PHASE_ITEMS  = 70;

  // register indexes
  localparam int unsigned REG_STEP_A = 0;
  localparam int unsigned REG_STEP_B = 1;
  localparam int unsigned REG_STEP_C = 2;
  localparam int unsigned REG_STEP_D = 3;

  // --------------------------------------------------------------------------
  // Model of the synth: phases, steps, held volume and the expected DAC codes
  // --------------------------------------------------------------------------
  class dac_tracker;
    logic signed [ROM_W-1:0] sine_tab [TBL];
    logic [STEP_W-1:0]       step_reg [NUM_VOICES];
    logic [STEP_W-1:0]       phase    [NUM_VOICES];
    logic [VOL_W-1:0]        vol_held;
    logic [SAMPLE_W-1:0]     dac_pending [$];
    int                      errors;

    // (a * b) >> 60 on 64-bit words, truncating
    function logic [63:0] mul_q60(logic [63:0] a, logic [63:0] b);
      logic [63:0] ah, al, bh, bl, hh, mid, ll;
      ah  = a >> 32;
      al  = a & 64'hFFFF_FFFF;
      bh  = b >> 32;
      bl  = b & 64'hFFFF_FFFF;
      hh  = ah * bh;
      mid = ah * bl + al * bh;
      ll  = al * bl;
      return (hh << 4) + (mid >> 28) + (ll >> 60);
    endfunction

    // one table entry: quadrant fold, Q4.60 Taylor series, scale to Q15
    function logic signed [ROM_W-1:0] sine_entry(int unsigned i);
      logic [63:0] n, m, d, x, x2, term, s, ph, pl, mag, k;
      longint      sum;
      bit          neg;
      n   = 64'(TBL);
      m   = 64'(i) * 4;
      d   = n * 2;
      neg = 1'b0;
      if (m >= d) begin
        neg = 1'b1;
        m   = m - d;
      end
      if (m > n) m = d - m;
      if (m == 0) return '0;
      if (m == n) begin
        mag = 64'd32767;
      end else begin
        // x = floor(pi * m / (2n)) in Q4.60
        ph   = (PI_Q60 >> 32) * m;
        pl   = ((ph % d) << 32) + (PI_Q60 & 64'hFFFF_FFFF) * m;
        x    = ((ph / d) << 32) + pl / d;
        x2   = mul_q60(x, x);
        term = x;
        sum  = longint'(x);
        for (k = 1; k < 24 && term != 0; k++) begin
          term = mul_q60(term, x2) / ((k * 2) * (k * 2 + 1));
          if (k[0]) sum -= longint'(term);
          else      sum += longint'(term);
        end
        s   = (sum > 0) ? 64'(sum) : 64'd0;
        mag = (64'd32767 * (s >> 30) + ((64'd32767 * (s & 64'h3FFF_FFFF)) >> 30)) >> 30;
        if (mag > 64'd32767) mag = 64'd32767;
      end
      return neg ? -ROM_W'(mag) : ROM_W'(mag);
    endfunction

    function new();
      for (int i = 0; i < TBL; i++) sine_tab[i] = sine_entry(i);
      for (int v = 0; v < NUM_VOICES; v++) begin
        step_reg[v] = '0;
        phase[v]    = '0;
      end
      vol_held = VOL_RESET;
      errors   = 0;
    endfunction

    // register write; zero step also clears the voice's phase
    function void write_step(int unsigned idx, logic [DATA_W-1:0] word);
      if (idx >= NUM_VOICES) return;
      step_reg[idx] = word[STEP_W-1:0];
      if (step_reg[idx] == '0) phase[idx] = '0;
    endfunction

    // accepted input transaction: advance one tick and queue its DAC code
    function void note_volume(logic [VOL_W-1:0] vol);
      logic [31:0] p;
      longint      mix, prod, scaled;
      int          vh;
      mix = 0;
      for (int v = 0; v < NUM_VOICES; v++) begin
        p        = ({6'd0, phase[v]} + {6'd0, step_reg[v]}) % SPAN;
        phase[v] = p[STEP_W-1:0];
        mix     += sine_tab[(p >> FRAC_W) % TBL];
      end
      vh     = int'(vol_held);
      prod   = mix * vh;
      scaled = (prod >>> FRAC_W) + 2048;
      if (scaled > 4095) scaled = 4095;
      if (scaled < 0)    scaled = 0;
      dac_pending.push_back(SAMPLE_W'(scaled));
      vol_held = vol;
    endfunction

    // accepted output transaction: compare against the oldest expected code
    function void check_dac(logic [SAMPLE_W-1:0] got);
      logic [SAMPLE_W-1:0] want;
      if (dac_pending.size() == 0) begin
        $display("%0t: unexpected dac_sample %0d", $time, got);
        errors++;
        return;
      end
      want = dac_pending.pop_front();
      if (got !== want) begin
        $display("%0t: dac_sample mismatch: expected %0d, got %0d", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic                clk           = 1'b0;
  logic                rst           = 1'b1;
  logic                psel          = 1'b0;
  logic                penable       = 1'b0;
  logic                pwrite        = 1'b0;
  logic [ADDR_W-1:0]   paddr         = '0;
  logic [DATA_W-1:0]   pwdata        = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                in_valid      = 1'b0;
  logic                in_stall;
  logic [VOL_W-1:0]    volume_sample = '0;
  logic                out_valid;
  logic                out_stall     = 1'b0;
  logic [SAMPLE_W-1:0] dac_sample;

  dac_tracker tracker = new();

  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int hold_seq     = 0;
  int hold_seen    = 0;
  int hold_left    = 0;
  int cycle_count  = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  four_voice_wavetable_synth_unit #(
    .TABLE_SIZE(TBL)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .volume_sample(volume_sample),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .dac_sample   (dac_sample)
  );

  // --------------------------------------------------------------------------
  // Monitors: both channels sampled at the edge that completes a transaction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) tracker.check_dac(dac_sample);
      if (in_valid && !in_stall)   tracker.note_volume(volume_sample);
    end
  end

  // receiver: random stalls, plus a long hold-off each time one is requested
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("four_voice_wavetable_synth_unit verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // one APB write, setup then access; upper data bits carry junk
  task automatic apb_write(int unsigned idx, logic [STEP_W-1:0] step);
    logic [DATA_W-1:0] word;
    word    = {6'($urandom()), step};
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(idx * 4);
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tracker.write_step(idx, word);
  endtask

  task automatic apb_release();
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // one input transaction, after a random gap
  task automatic send_volume(logic [VOL_W-1:0] vol);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    volume_sample <= vol;
    do @(posedge clk); while (in_stall);
  endtask

  // stop sending and wait until every expected code has come out; the extra
  // edge lets the monitor log the last input before the queue is polled
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.dac_pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    logic [STEP_W-1:0] step;
    logic [VOL_W-1:0]  vol;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // first tick runs on the reset volume: only voice A at its peak
    apb_write(REG_STEP_A, QUARTER_STEP);
    apb_release();
    send_volume(12'd4095);
    send_volume(12'd4095);
    send_volume(12'd0);
    send_volume(12'd4095);
    send_volume(12'd1);
    drain();

    // all voices aligned on quarter steps: clamp at both rails
    apb_write(REG_STEP_A, '0);
    apb_write(REG_STEP_A, QUARTER_STEP);
    apb_write(REG_STEP_B, QUARTER_STEP);
    apb_write(REG_STEP_C, QUARTER_STEP);
    apb_write(REG_STEP_D, QUARTER_STEP);
    apb_release();
    send_volume(12'd4095);
    send_volume(12'd4095);
    send_volume(12'd4095);
    send_volume(12'd4095);
    send_volume(12'd4095);
    send_volume(12'd0);
    send_volume(12'd2048);
    drain();

    // zero step clears, oversized steps, exact span and the largest legal step
    apb_write(REG_STEP_A, '0);
    apb_write(REG_STEP_B, STEP_ALL1);
    apb_write(REG_STEP_C, STEP_W'(SPAN));
    apb_write(REG_STEP_D, STEP_W'(SPAN - 1));
    apb_release();
    send_volume(12'd4094);
    send_volume(12'd1);
    send_volume(12'd2047);
    send_volume(12'd4095);
    send_volume(12'd0);
    drain();

    // smallest steps and a step just short of a full cycle
    apb_write(REG_STEP_A, STEP_W'(1));
    apb_write(REG_STEP_B, STEP_W'(1) << FRAC_W);
    apb_write(REG_STEP_C, STEP_W'(999) << FRAC_W);
    apb_write(REG_STEP_D, '0);
    apb_release();
    send_volume(12'd3000);
    send_volume(12'd4095);
    send_volume(12'd1365);
    send_volume(12'd2730);
    drain();

    // random phases with fresh steps and varying flow control
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      for (int unsigned v = 0; v < NUM_VOICES; v++) begin
        case ($urandom_range(9))
          0:       step = '0;
          1:       step = STEP_W'($urandom());
          2:       step = STEP_W'($urandom_range(1, 262143));
          3:       step = STEP_W'($urandom_range(1, TBL - 1)) << FRAC_W;
          default: step = STEP_W'($urandom_range(1, SPAN - 1));
        endcase
        apb_write(REG_STEP_A + v, step);
      end
      apb_release();

      case (ph % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct <= 0;  end
        1: begin tx_idle_pct = 63; rx_stall_pct <= 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct <= 63; end
        default: begin tx_idle_pct = 28; rx_stall_pct <= 28; end
      endcase

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // long output hold-off while the sender keeps offering
        if (ph == 0 && n == 20) hold_seq <= hold_seq + 1;
        case ($urandom_range(15))
          0:       vol = '0;
          1:       vol = {VOL_W{1'b1}};
          default: vol = VOL_W'($urandom_range(4095));
        endcase
        send_volume(vol);
      end
      drain();
    end

    if (tracker.errors == 0) begin
      $display("four_voice_wavetable_synth_unit verification clean");
    end else begin
      $display("four_voice_wavetable_synth_unit verification failed");
    end
    $finish;
  end

endmodule
